FILE: rtl/assert_macros.svh
// Assertion macros used by the bound protocol checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When a holds at a clock edge, b must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");

// When a holds at a clock edge, b must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/pkf_pkg.sv
package pkf_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_W = 16;
  localparam int SEQ_W = 16;

  localparam logic [7:0] HDR0 = 8'h57;
  localparam logic [7:0] HDR1 = 8'h41;
  localparam logic [7:0] HDR2 = 8'h56;
  localparam logic [7:0] TRAILER_CR = 8'h0D;
  localparam logic [7:0] CMD_RESET = 8'h69;

  // Position of the byte being sent within one queued job.
  typedef enum logic [3:0] {
    POS_H0,
    POS_H1,
    POS_H2,
    POS_SEQ_HI,
    POS_SEQ_LO,
    POS_LEN_HI,
    POS_LEN_LO,
    POS_CMD,
    POS_DATA,
    POS_SUM,
    POS_XOR,
    POS_CR
  } pkf_pos_t;

  // One accepted payload byte, classified and ready to send.
  typedef struct packed {
    logic             first;
    logic             last;
    logic [7:0]       data;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] lenf;
    logic [7:0]       cmd;
    logic [7:0]       sum;
    logic [7:0]       chk_xor;
  } pkf_job_t;

endpackage

FILE: rtl/pkf_fifo.sv
module pkf_fifo #(
  parameter int DEPTH = pkf_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pkf_pkg::pkf_job_t din,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output pkf_pkg::pkf_job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pkf_pkg::pkf_job_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/pkf_front.sv
module pkf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic [8:0]        in_payload_len,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output pkf_pkg::pkf_job_t q_din
);

  localparam logic [pkf_pkg::LEN_W-1:0] LEN_MAX = pkf_pkg::LEN_W'(pkf_pkg::MAX_PAYLOAD);

  logic [7:0]                cmd_r, cmd_nxt;
  logic                      in_packet_r, in_packet_nxt;
  logic [pkf_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [pkf_pkg::LEN_W-1:0] plen_c;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;

  always_comb begin
    plen_c = pkf_pkg::LEN_W'(in_payload_len);
    if (plen_c == '0) begin
      plen_c = pkf_pkg::LEN_W'(1);
    end
    if (plen_c > LEN_MAX) begin
      plen_c = LEN_MAX;
    end
  end

  always_comb begin
    cmd_nxt       = (cfg_valid && cfg_ready) ? cfg_data : cmd_r;
    in_packet_nxt = in_packet_r;
    seq_nxt       = seq_r;
    sum_nxt       = sum_r;
    xor_nxt       = xor_r;
    if (accept) begin
      if (!in_packet_r) begin
        // A new packet: the check bytes restart from the command byte.
        seq_nxt = seq_r + pkf_pkg::SEQ_W'(1);
        sum_nxt = cmd_r + in_data_byte;
        xor_nxt = cmd_r ^ in_data_byte;
      end else begin
        sum_nxt = sum_r + in_data_byte;
        xor_nxt = xor_r ^ in_data_byte;
      end
      in_packet_nxt = !in_last_byte;
    end
  end

  always_comb begin
    q_din.first   = !in_packet_r;
    q_din.last    = in_last_byte;
    q_din.data    = in_data_byte;
    q_din.seq     = seq_nxt;
    q_din.lenf    = plen_c + pkf_pkg::LEN_W'(1);
    q_din.cmd     = cmd_r;
    q_din.sum     = sum_nxt;
    q_din.chk_xor = xor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= pkf_pkg::CMD_RESET;
      in_packet_r <= 1'b0;
      seq_r       <= '0;
      sum_r       <= '0;
      xor_r       <= '0;
    end else begin
      cmd_r       <= cmd_nxt;
      in_packet_r <= in_packet_nxt;
      seq_r       <= seq_nxt;
      sum_r       <= sum_nxt;
      xor_r       <= xor_nxt;
    end
  end

endmodule

FILE: rtl/pkf_back.sv
module pkf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pkf_pkg::pkf_job_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_frame_end
);

  pkf_pkg::pkf_pos_t step_r, step_nxt;
  pkf_pkg::pkf_pos_t pos, pos_succ;
  logic              mid_r, mid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              run_last_r, frame_end_r;
  logic              emit, job_end;

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

  // Between jobs the position comes from the head job's kind.
  always_comb begin
    if (mid_r) begin
      pos = step_r;
    end else if (q_head.first) begin
      pos = pkf_pkg::POS_H0;
    end else begin
      pos = pkf_pkg::POS_DATA;
    end
  end

  assign emit    = q_valid && (!out_valid_r || out_ready);
  assign job_end = ((pos == pkf_pkg::POS_DATA) && !q_head.last) || (pos == pkf_pkg::POS_CR);
  assign q_pop   = emit && job_end;

  always_comb begin
    unique case (pos)
      pkf_pkg::POS_H0:     begin pos_succ = pkf_pkg::POS_H1;     byte_nxt = pkf_pkg::HDR0; end
      pkf_pkg::POS_H1:     begin pos_succ = pkf_pkg::POS_H2;     byte_nxt = pkf_pkg::HDR1; end
      pkf_pkg::POS_H2:     begin pos_succ = pkf_pkg::POS_SEQ_HI; byte_nxt = pkf_pkg::HDR2; end
      pkf_pkg::POS_SEQ_HI: begin pos_succ = pkf_pkg::POS_SEQ_LO; byte_nxt = q_head.seq[15:8]; end
      pkf_pkg::POS_SEQ_LO: begin pos_succ = pkf_pkg::POS_LEN_HI; byte_nxt = q_head.seq[7:0]; end
      pkf_pkg::POS_LEN_HI: begin pos_succ = pkf_pkg::POS_LEN_LO; byte_nxt = q_head.lenf[15:8]; end
      pkf_pkg::POS_LEN_LO: begin pos_succ = pkf_pkg::POS_CMD;    byte_nxt = q_head.lenf[7:0]; end
      pkf_pkg::POS_CMD:    begin pos_succ = pkf_pkg::POS_DATA;   byte_nxt = q_head.cmd; end
      pkf_pkg::POS_DATA:   begin pos_succ = pkf_pkg::POS_SUM;    byte_nxt = q_head.data; end
      pkf_pkg::POS_SUM:    begin pos_succ = pkf_pkg::POS_XOR;    byte_nxt = q_head.sum; end
      pkf_pkg::POS_XOR:    begin pos_succ = pkf_pkg::POS_CR;     byte_nxt = q_head.chk_xor; end
      pkf_pkg::POS_CR:     begin pos_succ = pkf_pkg::POS_H0;     byte_nxt = pkf_pkg::TRAILER_CR; end
      default:             begin pos_succ = pkf_pkg::POS_H0;     byte_nxt = pkf_pkg::TRAILER_CR; end
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      mid_nxt       = !job_end;
      step_nxt      = pos_succ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pkf_pkg::POS_H0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r      <= byte_nxt;
      run_last_r  <= job_end;
      frame_end_r <= (pos == pkf_pkg::POS_CR);
    end
  end

endmodule

FILE: rtl/packet_framer_sum_xor.sv
// An accepted payload byte is queued as a job, then sent through a registered output stage.
// Throughput: one payload byte per cycle inside a packet while the queue has room; the output sequencer sets the pace.
// A packet's first byte yields 9 output bytes (12 if it also ends the packet), its last byte 4.
// Reset (rst_n low, synchronous) empties the queue and output stage, clears the sequence number,
// the in-packet flag and the check bytes, and loads the command code with 0x69.
module packet_framer_sum_xor #(
  parameter int QUEUE_DEPTH = pkf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel for the command code.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // Payload byte channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic [8:0] in_payload_len,
  input  logic       in_last_byte,
  // Framed byte stream.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  // The front end classifies each transaction as the first or a later byte of a
  // packet, keeps the sequence number and the running sum and XOR, and queues one
  // job per byte. Each job already carries every field its output bytes need, so
  // the back end never looks at front-end state.
  pkf_pkg::pkf_job_t q_din;
  pkf_pkg::pkf_job_t q_head;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_valid;

  pkf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_payload_len(in_payload_len),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_din         (q_din)
  );

  // The queue lets the front end keep taking bytes while the back end is busy
  // with a header or trailer, or while the output side stalls.
  pkf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  // The back end walks through the bytes of the head job, one per cycle unless the
  // output stalls, into a registered output stage, and pops the job after its final byte.
  pkf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_frame_end(out_frame_end)
  );

endmodule

FILE: rtl/pkf_checker.sv
`include "assert_macros.svh"

module pkf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);

  // The closing byte of a frame is always the last byte of its transaction.
  `ASSERT_SAME(a_end_is_run_last, clk, rst_n, out_valid && out_frame_end, out_run_last)

  // The closing byte of a frame carries the carriage return code.
  `ASSERT_SAME(a_end_is_cr, clk, rst_n, out_valid && out_frame_end, out_byte == pkf_pkg::TRAILER_CR)

  // A stalled output byte stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))

endmodule

bind packet_framer_sum_xor pkf_checker u_pkf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_run_last (out_run_last),
  .out_frame_end(out_frame_end)
);

FILE: tb/framed_stream_checker.sv
`timescale 1ns / 1ps
module framed_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic [8:0] in_payload_len,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_frame_end,
  output int         fail_count,
  output int         pending_count,
  output int         bytes_checked
);

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  framed_byte_t expected_bytes[$];

  // Shadow copy of the framer state.
  logic [7:0]  command_copy;
  logic        frame_open;
  logic [15:0] seq_count;
  logic [7:0]  sum_acc;
  logic [7:0]  xor_acc;
  int          mismatches;
  int          compared;

  task automatic queue_byte(input logic [7:0] value, input logic frame_end);
    framed_byte_t entry;
    entry.value     = value;
    entry.run_last  = 1'b0;
    entry.frame_end = frame_end;
    expected_bytes.push_back(entry);
  endtask

  // Appends every framed byte that one payload byte produces.
  task automatic predict_framed_bytes(input logic [7:0] data, input logic [8:0] plen,
                                      input logic last);
    logic [8:0]   clamped;
    logic [15:0]  len_field;
    framed_byte_t tail;
    if (!frame_open) begin
      clamped = plen;
      if (clamped == 9'd0) clamped = 9'd1;
      if (clamped > 9'(pkf_pkg::MAX_PAYLOAD)) clamped = 9'(pkf_pkg::MAX_PAYLOAD);
      len_field = 16'(clamped) + 16'd1;
      seq_count = seq_count + 16'd1;
      queue_byte(pkf_pkg::HDR0, 1'b0);
      queue_byte(pkf_pkg::HDR1, 1'b0);
      queue_byte(pkf_pkg::HDR2, 1'b0);
      queue_byte(seq_count[15:8], 1'b0);
      queue_byte(seq_count[7:0], 1'b0);
      queue_byte(len_field[15:8], 1'b0);
      queue_byte(len_field[7:0], 1'b0);
      queue_byte(command_copy, 1'b0);
      sum_acc    = command_copy;
      xor_acc    = command_copy;
      frame_open = 1'b1;
    end
    queue_byte(data, 1'b0);
    sum_acc = sum_acc + data;
    xor_acc = xor_acc ^ data;
    if (last) begin
      queue_byte(sum_acc, 1'b0);
      queue_byte(xor_acc, 1'b0);
      queue_byte(pkf_pkg::TRAILER_CR, 1'b1);
      frame_open = 1'b0;
      sum_acc    = 8'd0;
      xor_acc    = 8'd0;
    end
    tail = expected_bytes.pop_back();
    tail.run_last = 1'b1;
    expected_bytes.push_back(tail);
  endtask

  always @(posedge clk) begin
    framed_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      command_copy = pkf_pkg::CMD_RESET;
      frame_open   = 1'b0;
      seq_count    = 16'd0;
      sum_acc      = 8'd0;
      xor_acc      = 8'd0;
      mismatches   = 0;
      compared     = 0;
    end else begin
      // Outputs are retired before new inputs are predicted, so a byte that
      // shows up too early is not matched against its own prediction.
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected framed byte 0x%02h with nothing expected", out_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          compared++;
          if (out_byte !== want.value) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.value, out_byte);
            mismatches++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %0b, actual %0b", want.run_last, out_run_last);
            mismatches++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("out_frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) command_copy = cfg_data;
      if (in_valid && in_ready) predict_framed_bytes(in_data_byte, in_payload_len, in_last_byte);
    end
    fail_count    <= mismatches;
    pending_count <= expected_bytes.size();
    bytes_checked <= compared;
  end

endmodule

FILE: tb/tb_packet_framer_sum_xor.sv
`timescale 1ns / 1ps
module tb_packet_framer_sum_xor;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 150;
  // The final stretch of the random part runs with no idling on either side.
  localparam int QUIET_ITEMS   = 30;
  // Receiver hold-off used to fill the framer queue and back up the input.
  localparam int LONG_HOLD     = 120;
  // Extra wait after the checker owes nothing, before the framer is treated as idle.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int CFG_EVERY     = 8;
  localparam int HOLD_FRAME    = 5;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic [8:0] in_payload_len;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_frame_end;

  // Shared stimulus controls. Both are written with nonblocking assignments
  // by the main sequence and only read elsewhere.
  logic idle_en;
  int   hold_requests;

  int items_sent;
  int frames_sent;
  int cfg_writes;
  int random_frames;
  int cycle_count;

  int fail_count;
  int pending_count;
  int bytes_checked;

  always #(HALF_PERIOD) clk = ~clk;

  packet_framer_sum_xor u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_payload_len(in_payload_len),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

  // The checker watches all three channels, predicts the framed stream and
  // reports how many mismatches it found and how many bytes are still owed.
  framed_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_payload_len(in_payload_len),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .bytes_checked (bytes_checked)
  );

  // Offers one payload byte and returns at the edge where the transaction
  // completes. Valid stays high on return so that back-to-back bytes flow
  // without a bubble; a random gap drops it first when idling is enabled.
  task automatic send_payload_byte(input logic [7:0] data, input logic [8:0] plen,
                                   input logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= data;
    in_payload_len <= plen;
    in_last_byte   <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (last) frames_sent++;
  endtask

  // Stops offering input and waits until the checker owes nothing. The
  // pending count is registered, so it reflects every transaction up to
  // the previous edge.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The command register is only written while the framer has nothing in
  // flight, so the checker can apply the write at the edge it sees it.
  task automatic write_command(input logic [7:0] code);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Receiver: random short stalls while idling is enabled, plus one long
  // hold-off per request from the main sequence. The hold is counted here
  // while the sender keeps offering bytes, so the framer queue fills and
  // in_ready drops.
  initial begin
    int served;
    served = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that has not finished by the limit is a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int         nbytes;
    int         random_start;
    logic [8:0] declared;
    items_sent     = 0;
    frames_sent    = 0;
    cfg_writes     = 0;
    random_frames  = 0;
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= 8'h00;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'h00;
    in_payload_len <= 9'd0;
    in_last_byte   <= 1'b0;
    idle_en        <= 1'b0;
    hold_requests  <= 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n   <= 1'b1;
    idle_en <= 1'b1;
    @(posedge clk);

    // Directed part. A single-byte frame with the reset command code and the
    // smallest data value, then one with the largest data value and a zero
    // declared length, which must be framed as a length of one.
    send_payload_byte(8'h00, 9'd1, 1'b1);
    send_payload_byte(8'hff, 9'd0, 1'b1);

    // All nine length bits set: the length saturates at the maximum payload length.
    // The packet is also far shorter than it claims.
    send_payload_byte(8'ha5, 9'h1ff, 1'b0);
    send_payload_byte(8'h5a, 9'd0, 1'b1);

    // Exactly the maximum length. Later bytes carry junk lengths, which the
    // framer must ignore since the length is read on the first byte only.
    send_payload_byte(8'h01, 9'd256, 1'b0);
    send_payload_byte(8'h80, 9'h155, 1'b0);
    send_payload_byte(8'h7f, 9'h0aa, 1'b1);

    // One past the maximum.
    send_payload_byte(8'h3c, 9'd257, 1'b1);

    // More bytes than declared: only the last-byte flag closes the frame.
    send_payload_byte(8'h11, 9'd1, 1'b0);
    send_payload_byte(8'h22, 9'd1, 1'b0);
    send_payload_byte(8'h33, 9'd1, 1'b1);

    // The command changes in the middle of a packet. The open frame keeps
    // the code it latched on its first byte; the next frame uses the new one.
    send_payload_byte(8'h12, 9'd3, 1'b0);
    write_command(8'h00);
    send_payload_byte(8'h34, 9'd3, 1'b0);
    send_payload_byte(8'h56, 9'd3, 1'b1);
    send_payload_byte(8'hc3, 9'd1, 1'b1);

    // The other extreme of the command code.
    write_command(8'hff);
    send_payload_byte(8'hee, 9'd2, 1'b0);
    send_payload_byte(8'hdd, 9'd2, 1'b1);

    // Random part. Most packets are short and well formed; some are long,
    // and a share declare a random length that need not match the count.
    // The command code is changed every few frames between packets.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start >= RANDOM_ITEMS - QUIET_ITEMS) idle_en <= 1'b0;
      if (random_frames % CFG_EVERY == CFG_EVERY - 1)
        write_command(8'($urandom_range(0, 255)));
      if (random_frames == HOLD_FRAME) hold_requests <= hold_requests + 1;
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) < 6) declared = 9'(nbytes);
      else declared = 9'($urandom_range(0, 511));
      for (int i = 0; i < nbytes; i++) begin
        send_payload_byte(8'($urandom_range(0, 255)),
                          (i == 0) ? declared : 9'($urandom_range(0, 511)),
                          i == nbytes - 1);
      end
      random_frames++;
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d payload transactions in %0d frames, with %0d command writes.",
             items_sent, frames_sent, cfg_writes);
    $display("Compared %0d framed bytes and found %0d mismatches.", bytes_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
